[sv/pbmc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables for the pixel blend-mode compositor.
// Used by pbmc_lane, pbmc_merge and the top level; depends on nothing.
package pbmc_pkg;

	// Q16 fixed point: 1.0 is 2^16, held in 17 bits
	localparam int Q_FRAC = 16;
	localparam int Q_W = Q_FRAC + 1;
	localparam logic [Q_W-1:0] Q_ONE = 17'h1_0000;
	localparam logic [Q_W-1:0] Q_HALF = 17'h0_8000;
	localparam logic [Q_W-1:0] Q_QUARTER = 17'h0_4000;

	// Register stages inside one lane; the merge register follows them
	localparam int LANE_STAGES = 8;
	localparam int NUM_LANES = 4;
	localparam int MODE_W = 4;

	// Blend mode codes; the two unused codes behave as normal
	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL     = 4'd0,
		MODE_PLUS       = 4'd1,
		MODE_DODGE      = 4'd2,
		MODE_SCREEN     = 4'd3,
		MODE_LIGHTEN    = 4'd4,
		MODE_BURN       = 4'd5,
		MODE_MULTIPLY   = 4'd6,
		MODE_DARKEN     = 4'd7,
		MODE_OVERLAY    = 4'd8,
		MODE_HARD_LIGHT = 4'd9,
		MODE_SOFT_LIGHT = 4'd10,
		MODE_XOR        = 4'd11,
		MODE_DIFFERENCE = 4'd12,
		MODE_EXCLUSION  = 4'd13
	} blend_mode_t;

	// What a lane hands to the merge stage
	typedef struct packed {
		logic [32:0] val; // composited value, Q32, saturated to 1.0
		logic [7:0]  dst; // untouched destination channel
	} lane_res_t;

	// Square-root table for soft light: floor(sqrt(floor(c * 2^32 / 255)))
	typedef logic [255:0][Q_W-1:0] sq_rom_t;

	function automatic sq_rom_t build_sq_rom();
		sq_rom_t rom;
		logic [40:0] x;
		logic [Q_W-1:0] r;
		logic [Q_W-1:0] t;
		logic [40:0] tt;
		for (int c = 0; c < 256; c++) begin
			x = (41'(c) << 32) / 41'd255;
			r = '0;
			for (int b = Q_W - 1; b >= 0; b--) begin
				t = r | (17'd1 << b);
				tt = 41'(t) * 41'(t);
				if (tt <= x) begin
					r = t;
				end
			end
			rom[c] = r;
		end
		return rom;
	endfunction

	localparam sq_rom_t SQ_ROM = build_sq_rom();

	// 8-bit channel to Q16: c * 257 plus one for the upper half
	function automatic logic [Q_W-1:0] to_q16(logic [7:0] c);
		return 17'({c, 8'h00}) + 17'(c) + 17'(c[7]);
	endfunction

endpackage

[sv/pbmc_lane.sv]
`timescale 1ns / 1ps
// One channel lane: blend by mode, then source-over composite, eight stages.
// Depends on pbmc_pkg; four copies sit in the top level.
module pbmc_lane (
	input  logic                                  clk,
	input  logic [pbmc_pkg::LANE_STAGES-1:0]      stage_en,
	input  logic [pbmc_pkg::MODE_W-1:0]           mode,
	input  logic                                  force_one,
	input  logic [7:0]                            dst_chan,
	input  logic [7:0]                            src_chan,
	input  logic [7:0]                            dst_alpha,
	input  logic [7:0]                            src_alpha,
	output pbmc_pkg::lane_res_t                   res
);
	import pbmc_pkg::*;

	localparam int DIV_STEPS = 4;
	localparam int C_W = 20;

	// Long division state for dodge and burn
	typedef struct packed {
		logic [Q_W-1:0]    rem;
		logic [Q_FRAC-1:0] quo;
		logic [Q_W-1:0]    den;
		logic              big;
	} div_t;

	function automatic div_t div_step(div_t x);
		div_t y;
		logic [Q_W:0] r2;
		y = x;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r2 = {y.rem, 1'b0};
			if (r2 >= {1'b0, y.den}) begin
				y.rem = Q_W'(r2 - {1'b0, y.den});
				y.quo = {y.quo[Q_FRAC-2:0], 1'b1};
			end else begin
				y.rem = r2[Q_W-1:0];
				y.quo = {y.quo[Q_FRAC-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	function automatic logic signed [C_W-1:0] sx(logic [Q_W-1:0] v);
		return $signed({3'b000, v});
	endfunction

	// ---- stage 1: input conversion
	logic [Q_W-1:0] d_s1, s_s1, sa_s1, da_s1;
	logic [7:0] dc_s1;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			d_s1  <= to_q16(dst_chan);
			s_s1  <= to_q16(src_chan);
			sa_s1 <= to_q16(src_alpha);
			da_s1 <= to_q16(dst_alpha);
			dc_s1 <= dst_chan;
		end
	end

	// ---- stage 2: products and divider setup
	logic s_lo_1;
	logic [Q_W-1:0] soft_a_1;
	logic is_burn_1;
	logic [Q_W-1:0] num_1, den_1;
	div_t div_init_1;

	assign s_lo_1 = (s_s1 <= Q_HALF);
	assign soft_a_1 = s_lo_1 ? Q_W'(18'(Q_ONE) - {s_s1, 1'b0}) : d_s1;
	assign is_burn_1 = (mode == MODE_BURN);
	assign num_1 = is_burn_1 ? (Q_ONE - d_s1) : d_s1;
	assign den_1 = is_burn_1 ? s_s1 : (Q_ONE - s_s1);

	always_comb begin
		div_init_1.den = den_1;
		div_init_1.big = (num_1 >= den_1);
		div_init_1.rem = div_init_1.big ? '0 : num_1;
		div_init_1.quo = '0;
	end

	logic [32:0] pm_ds_s2, pm_inv_s2, px1_s2, px2_s2, soft_p_s2;
	logic [Q_W-1:0] d_s2, s_s2, sa_s2;
	logic [7:0] dc_s2;
	div_t div_s2;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			pm_ds_s2  <= 33'(34'(d_s1) * 34'(s_s1));
			pm_inv_s2 <= 33'(34'(Q_ONE - d_s1) * 34'(Q_ONE - s_s1));
			px1_s2    <= 33'(34'(d_s1) * 34'(Q_ONE - sa_s1));
			px2_s2    <= 33'(34'(s_s1) * 34'(Q_ONE - da_s1));
			soft_p_s2 <= 33'(34'(soft_a_1) * 34'(d_s1));
			d_s2      <= d_s1;
			s_s2      <= s_s1;
			sa_s2     <= sa_s1;
			dc_s2     <= dc_s1;
			div_s2    <= div_init_1;
		end
	end

	// ---- stage 3: product-based modes, soft light second product and cubic term
	logic [Q_W-1:0] mul_r_2, px1_r_2, px2_r_2;
	logic [Q_W:0] mul2_r_2, inv2_r_2;
	logic [33:0] mul2_sum_2, inv2_sum_2;
	logic [32:0] mul_sum_2, px1_sum_2, px2_sum_2;
	logic signed [C_W-1:0] c_2;
	logic signed [39:0] inner_full_2;
	logic [33:0] inner_2;
	logic ovl_test_2;

	assign mul_sum_2 = pm_ds_s2 + 33'(Q_HALF);
	assign px1_sum_2 = px1_s2 + 33'(Q_HALF);
	assign px2_sum_2 = px2_s2 + 33'(Q_HALF);
	assign mul2_sum_2 = {pm_ds_s2, 1'b0} + 34'(Q_HALF);
	assign inv2_sum_2 = {pm_inv_s2, 1'b0} + 34'(Q_HALF);
	assign mul_r_2 = mul_sum_2[32:16];
	assign px1_r_2 = px1_sum_2[32:16];
	assign px2_r_2 = px2_sum_2[32:16];
	assign mul2_r_2 = mul2_sum_2[33:16];
	assign inv2_r_2 = inv2_sum_2[33:16];
	assign ovl_test_2 = ((mode == MODE_OVERLAY) ? d_s2 : s_s2) < Q_HALF;

	always_comb begin
		case (mode)
			MODE_PLUS:       c_2 = sx(d_s2) + sx(s_s2);
			MODE_SCREEN:     c_2 = sx(d_s2) + sx(s_s2) - sx(mul_r_2);
			MODE_LIGHTEN:    c_2 = (d_s2 > s_s2) ? sx(d_s2) : sx(s_s2);
			MODE_MULTIPLY:   c_2 = sx(mul_r_2);
			MODE_DARKEN:     c_2 = (d_s2 < s_s2) ? sx(d_s2) : sx(s_s2);
			MODE_OVERLAY, MODE_HARD_LIGHT: begin
				if (ovl_test_2) begin
					c_2 = $signed({2'b00, mul2_r_2});
				end else begin
					c_2 = sx(Q_ONE) - $signed({2'b00, inv2_r_2});
				end
			end
			MODE_XOR:        c_2 = sx(px1_r_2) + sx(px2_r_2);
			MODE_DIFFERENCE: c_2 = (d_s2 > s_s2) ? sx(d_s2 - s_s2) : sx(s_s2 - d_s2);
			MODE_EXCLUSION:  c_2 = sx(d_s2) + sx(s_s2) - $signed({2'b00, mul2_r_2});
			default:         c_2 = sx(s_s2);
		endcase
	end

	// 16 d^2 - 12 d ONE + 3 ONE^2, only needed up to a quarter
	assign inner_full_2 = $signed({3'b000, soft_p_s2, 4'b0000})
		- $signed({4'b0000, d_s2, 19'b0}) - $signed({5'b00000, d_s2, 18'b0})
		+ 40'sh03_0000_0000;
	assign inner_2 = (d_s2 <= Q_QUARTER) ? inner_full_2[33:0] : '0;

	logic signed [C_W-1:0] c_s3;
	logic [49:0] t2_s3;
	logic [33:0] inner_s3;
	logic [Q_W-1:0] d_s3, s_s3, sa_s3;
	logic [7:0] dc_s3;
	div_t div_s3;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			c_s3     <= c_2;
			t2_s3    <= 50'(soft_p_s2) * 50'(Q_ONE - d_s2);
			inner_s3 <= inner_2;
			d_s3     <= d_s2;
			s_s3     <= s_s2;
			sa_s3    <= sa_s2;
			dc_s3    <= dc_s2;
			div_s3   <= div_step(div_s2);
		end
	end

	// ---- stage 4: soft light low branch, cubic rounding, root lookup
	logic [50:0] t2_sum_3;
	logic [51:0] cub_sum_3;

	assign t2_sum_3 = 51'(t2_s3) + 51'h0_8000_0000;
	assign cub_sum_3 = 52'(d_s3) * 52'(inner_s3) + 52'h0_8000_0000;

	logic signed [C_W-1:0] soft_lo_s4, c_s4;
	logic [Q_W-1:0] g_cub_s4, sq_s4, d_s4, s_s4, sa_s4;
	logic [7:0] dc_s4;
	div_t div_s4;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			soft_lo_s4 <= sx(d_s3) - $signed({1'b0, t2_sum_3[50:32]});
			g_cub_s4   <= Q_W'(cub_sum_3[51:32]);
			sq_s4      <= SQ_ROM[dc_s3];
			c_s4       <= c_s3;
			d_s4       <= d_s3;
			s_s4       <= s_s3;
			sa_s4      <= sa_s3;
			dc_s4      <= dc_s3;
			div_s4     <= div_step(div_s3);
		end
	end

	// ---- stage 5: soft light high branch product
	logic [Q_W-1:0] g_4, k_4;

	assign g_4 = (d_s4 <= Q_QUARTER) ? g_cub_s4 : ((sq_s4 > d_s4) ? (sq_s4 - d_s4) : '0);
	assign k_4 = (s_s4 <= Q_HALF) ? '0 : Q_W'({s_s4, 1'b0} - 18'(Q_ONE));

	logic [33:0] kg_s5;
	logic signed [C_W-1:0] soft_lo_s5, c_s5;
	logic [Q_W-1:0] d_s5, s_s5, sa_s5;
	logic [7:0] dc_s5;
	div_t div_s5;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			kg_s5      <= 34'(k_4) * 34'(g_4);
			soft_lo_s5 <= soft_lo_s4;
			c_s5       <= c_s4;
			d_s5       <= d_s4;
			s_s5       <= s_s4;
			sa_s5      <= sa_s4;
			dc_s5      <= dc_s4;
			div_s5     <= div_step(div_s4);
		end
	end

	// ---- stage 6: soft light result, last quotient bits
	logic [33:0] kg_sum_5;
	logic signed [C_W-1:0] soft_5;

	assign kg_sum_5 = kg_s5 + 34'(Q_HALF);
	assign soft_5 = (s_s5 <= Q_HALF) ? soft_lo_s5 : (sx(d_s5) + sx(kg_sum_5[32:16]));

	logic signed [C_W-1:0] soft_s6, c_s6;
	logic [Q_W-1:0] d_s6, s_s6, sa_s6;
	logic [7:0] dc_s6;
	div_t div_s6;

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			soft_s6 <= soft_5;
			c_s6    <= c_s5;
			d_s6    <= d_s5;
			s_s6    <= s_s5;
			sa_s6   <= sa_s5;
			dc_s6   <= dc_s5;
			div_s6  <= div_step(div_s5);
		end
	end

	// ---- stage 7: final blend select, composite products
	logic [Q_W-1:0] qv_6;
	logic signed [C_W-1:0] sel_6;
	logic [Q_W:0] cu_6;

	assign qv_6 = div_s6.big ? Q_ONE : {1'b0, div_s6.quo};

	always_comb begin
		case (mode)
			MODE_DODGE:      sel_6 = (s_s6 >= Q_ONE) ? sx(Q_ONE) : sx(qv_6);
			MODE_BURN:       sel_6 = (s_s6 == '0) ? '0 : sx(Q_ONE - qv_6);
			MODE_SOFT_LIGHT: sel_6 = soft_s6;
			default:         sel_6 = c_s6;
		endcase
	end

	// the alpha lane composites 1.0 over destination alpha
	assign cu_6 = force_one ? {1'b0, Q_ONE} : (sel_6 < 0 ? '0 : sel_6[Q_W:0]);

	logic [34:0] p_src_s7, p_dst_s7;
	logic [7:0] dc_s7;

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			p_src_s7 <= 35'(cu_6) * 35'(sa_s6);
			p_dst_s7 <= 35'(d_s6) * 35'(Q_ONE - sa_s6);
			dc_s7    <= dc_s6;
		end
	end

	// ---- stage 8: sum and saturate to 1.0
	logic [35:0] sum_7;

	assign sum_7 = 36'(p_src_s7) + 36'(p_dst_s7);

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			res.val <= (sum_7 > 36'h1_0000_0000) ? 33'h1_0000_0000 : sum_7[32:0];
			res.dst <= dc_s7;
		end
	end

endmodule

[sv/pbmc_merge.sv]
`timescale 1ns / 1ps
// Merge stage: rounds each lane to 8 bits, applies alpha-zero pass-through
// and packs the output beat register. Depends on pbmc_pkg.
module pbmc_merge (
	input  logic                  clk,
	input  logic                  load,
	input  logic                  pass,
	input  pbmc_pkg::lane_res_t   lanes [pbmc_pkg::NUM_LANES],
	output logic [31:0]           tdata // out_red, out_green, out_blue, out_alpha
);
	import pbmc_pkg::*;

	// round Q32 to 8 bits: (v * 255 + 2^31) >> 32
	function automatic logic [7:0] q32_to_8(logic [32:0] v);
		logic [41:0] acc;
		acc = {1'b0, v, 8'h00} - 42'(v) + 42'h0_8000_0000;
		return acc[39:32];
	endfunction

	logic [31:0] tdata_q;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				tdata_q[8*i +: 8] <= pass ? lanes[i].dst : q32_to_8(lanes[i].val);
			end
		end
	end

	assign tdata = tdata_q;

endmodule

[sv/pixel_blend_mode_compositor.sv]
`timescale 1ns / 1ps
// Pixel blend-mode compositor, top level.
// Input stream (s_*): one beat carries a destination and a source RGBA8 pixel.
// Output stream (m_*): one beat per input beat, the composited RGBA8 pixel.
// The colour channels are blended with the mode held in the blend_mode register
// (APB, byte address 0, bits 3:0) and composited source-over with source alpha;
// a source alpha of zero returns the destination pixel unchanged.
// Four lanes (red, green, blue, alpha) run side by side, eight register stages
// each, followed by the merge register that holds the output beat.
// Each beat passes the eight lane stages, then the merge register, to m_tvalid.
// Throughput: one beat per cycle unless the receiver stalls; dodge and burn
// use a long divider that yields four quotient bits per stage, which sets the
// pipeline depth. When the receiver stalls, held beats stay in place and empty
// stages still fill, so s_tready drops only once every stage holds a beat.
// Reset clears all valid flags and sets blend_mode to normal.
// The user must write blend_mode only while no beat is in flight; not enforced.
module pixel_blend_mode_compositor (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata, // dst_red, dst_green, dst_blue, dst_alpha,
	                             // src_red, src_green, src_blue, src_alpha
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata, // out_red, out_green, out_blue, out_alpha
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pbmc_pkg::*;

	localparam int TOTAL = LANE_STAGES + 1;

	// ---- configuration register
	logic [MODE_W-1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : {{(32-MODE_W){1'b0}}, mode_q};

	// ---- pipeline control: a stage advances when empty or when the next one does
	logic [TOTAL-1:0] vld_q;
	logic [TOTAL-1:0] en;
	logic [TOTAL-1:0] vld_in;

	always_comb begin
		en[TOTAL-1] = !vld_q[TOTAL-1] || m_tready;
		for (int k = TOTAL - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in = {vld_q[TOTAL-2:0], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < TOTAL; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[TOTAL-1];

	// ---- alpha-zero pass flag travels beside the lanes
	logic [LANE_STAGES-1:0] pass_q;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pass_q[0] <= (s_tdata[63:56] == 8'h00);
		end
		for (int k = 1; k < LANE_STAGES; k++) begin
			if (en[k]) begin
				pass_q[k] <= pass_q[k-1];
			end
		end
	end

	// ---- lanes: red, green, blue, then alpha
	lane_res_t lane_res [NUM_LANES];

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		pbmc_lane u_lane (
			.clk       (clk),
			.stage_en  (en[LANE_STAGES-1:0]),
			.mode      (mode_q),
			.force_one (1'(i == NUM_LANES - 1)),
			.dst_chan  (s_tdata[8*i +: 8]),
			.src_chan  (s_tdata[32 + 8*i +: 8]),
			.dst_alpha (s_tdata[31:24]),
			.src_alpha (s_tdata[63:56]),
			.res       (lane_res[i])
		);
	end

	// ---- merge and output register
	pbmc_merge u_merge (
		.clk   (clk),
		.load  (en[TOTAL-1]),
		.pass  (pass_q[LANE_STAGES-1]),
		.lanes (lane_res),
		.tdata (m_tdata)
	);

	// ---- checks
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted beat did not reach the first stage");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !m_tready) |-> !s_tready)
		else $error("input accepted while the pipeline is full and stalled");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pixel_blend_mode_compositor: directed corners, every blend
// mode and random pixel pairs, checked beat by beat against an in-bench Q16 predictor.
// Depends on pbmc_pkg (mode codes) and the top level of the block.
module testbench;
	import pbmc_pkg::*;

	localparam logic [2:0] BLEND_MODE_ADDR = 3'd0;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam longint ONE = 65536;
	localparam longint HALF = 32768;
	localparam longint QUARTER = 16384;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0; // dst r, g, b, a, src r, g, b, a
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata; // out r, g, b, a
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [3:0]  cur_mode = MODE_NORMAL;
	logic [31:0] pixels_due[$];
	int          fail_count = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	bit          hold_req = 1'b0;
	bit          ready_free = 1'b0;
	int          hold_left = 0;
	longint      sq_lut[256];

	pixel_blend_mode_compositor dut (.*);

	always #4 clk = ~clk;

	// Q16 helpers
	function automatic longint q16(input logic [7:0] c);
		return (longint'(c) * 65536 + 127) / 255;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + HALF) >>> 16;
	endfunction

	function automatic logic [7:0] q32_to_chan(input longint v);
		if (v > (longint'(1) << 32)) v = longint'(1) << 32;
		return 8'((v * 255 + (longint'(1) << 31)) >>> 32);
	endfunction

	// Blend of one colour channel in Q16, may exceed one
	function automatic longint blend_chan(input logic [3:0] mode, input longint d,
			input longint s, input logic [7:0] dc, input longint sa, input longint da);
		longint q, g, inner, t;
		case (mode)
			MODE_PLUS: return d + s;
			MODE_DODGE: begin
				if (s >= ONE) return ONE;
				q = d * ONE / (ONE - s);
				return (q > ONE) ? ONE : q;
			end
			MODE_SCREEN: return d + s - qmul(d, s);
			MODE_LIGHTEN: return (d > s) ? d : s;
			MODE_BURN: begin
				if (s == 0) return 0;
				q = (ONE - d) * ONE / s;
				return ONE - ((q > ONE) ? ONE : q);
			end
			MODE_MULTIPLY: return qmul(d, s);
			MODE_DARKEN: return (d < s) ? d : s;
			MODE_OVERLAY, MODE_HARD_LIGHT: begin
				if (((mode == MODE_OVERLAY) ? d : s) < HALF)
					return (2 * d * s + HALF) >>> 16;
				return ONE - ((2 * (ONE - d) * (ONE - s) + HALF) >>> 16);
			end
			MODE_SOFT_LIGHT: begin
				if (s <= HALF) begin
					t = (ONE - 2 * s) * d * (ONE - d);
					return d - ((t + (longint'(1) << 31)) >>> 32);
				end
				if (d <= QUARTER) begin
					inner = 16 * d * d - 12 * d * ONE + 3 * ONE * ONE;
					if (inner < 0) inner = 0;
					g = (d * inner + (longint'(1) << 31)) >>> 32;
				end else begin
					g = sq_lut[dc] - d;
					if (g < 0) g = 0;
				end
				return d + (((2 * s - ONE) * g + HALF) >>> 16);
			end
			MODE_XOR: return qmul(d, ONE - sa) + qmul(s, ONE - da);
			MODE_DIFFERENCE: return (d > s) ? d - s : s - d;
			MODE_EXCLUSION: return d + s - ((2 * d * s + HALF) >>> 16);
			default: return s;
		endcase
	endfunction

	// Composited output pixel for one input beat
	function automatic logic [31:0] composite_pixel(input logic [3:0] mode,
			input logic [63:0] px);
		logic [31:0] res;
		longint sa, da, d, s, c;
		if (px[63:56] == 8'd0) return px[31:0];
		sa = q16(px[63:56]);
		da = q16(px[31:24]);
		for (int i = 0; i < 3; i++) begin
			d = q16(px[8*i +: 8]);
			s = q16(px[32 + 8*i +: 8]);
			c = blend_chan(mode, d, s, px[8*i +: 8], sa, da);
			if (c < 0) c = 0;
			res[8*i +: 8] = q32_to_chan(c * sa + d * (ONE - sa));
		end
		res[31:24] = q32_to_chan(sa * ONE + da * (ONE - sa));
		return res;
	endfunction

	// Send one beat; bursts of random length with random gaps
	task automatic send_pixel(input logic [63:0] px);
		int gap;
		s_tdata <= px;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_due.push_back(composite_pixel(cur_mode, px));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
	endtask

	// Stop offering and wait for every expected pixel
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pixels_due.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// APB write then read back
	task automatic write_mode(input logic [3:0] mode);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= BLEND_MODE_ADDR; pwdata <= 32'(mode);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cur_mode = mode;
		@(negedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[3:0] !== mode)
			$error("blend_mode readback: expected %0d actual %0d", mode, prdata[3:0]);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_pixel();
		logic [63:0] px;
		px = {$urandom, $urandom};
		for (int i = 0; i < 8; i++)
			if ($urandom_range(0, 3) == 0) px[8*i +: 8] = rand_chan();
		return px;
	endfunction

	// Extremes and the named special cases
	task automatic test_corners();
		write_mode(MODE_NORMAL);
		send_pixel(64'h0000_0000_0000_0000);
		send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(64'h00AA_BBCC_8040_2010); // zero source alpha passes dst
		send_pixel(64'h80FF_00FF_FF00_FF00);
		drain();
		write_mode(MODE_PLUS);
		send_pixel(64'hFFF0_F0F0_FFF0_F0F0); // sum above one, saturated
		send_pixel(64'h7F80_8080_4080_8080);
		drain();
		write_mode(MODE_DODGE);
		send_pixel(64'hFFFF_FFFF_FF00_0000); // full source, dark dst
		send_pixel(64'hC0FE_01FF_40FF_8000);
		drain();
		write_mode(MODE_BURN);
		send_pixel(64'hFF00_0000_FFFF_FFFF); // zero source, white dst
		send_pixel(64'hC001_FF80_4000_FF7F);
		drain();
		write_mode(MODE_SOFT_LIGHT);
		send_pixel(64'hFF40_3F80_FF00_4041); // around the quarter point
		send_pixel(64'hFFFF_8081_FF01_80C0);
		drain();
		write_mode(4'd15);
		send_pixel(64'h8012_3456_FF65_4321);
		drain();
	endtask

	// Every mode code with random pixels
	task automatic test_all_modes(input int per_mode);
		for (int m = 0; m < 16; m++) begin
			write_mode(4'(m));
			send_pixel({8'hFF, 24'($urandom), 8'hFF, 24'($urandom)});
			for (int n = 0; n < per_mode; n++) send_pixel(rand_pixel());
			drain();
		end
	endtask

	// Long receiver hold-off so the pipeline fills and stalls its input
	task automatic test_backpressure();
		write_mode(MODE_SOFT_LIGHT);
		hold_req = 1'b1;
		for (int n = 0; n < 40; n++) send_pixel(rand_pixel());
		drain();
	endtask

	// One random mode, receiver never stalls
	task automatic test_full_rate();
		ready_free = 1'b1;
		write_mode(4'($urandom_range(0, 15)));
		for (int n = 0; n < 80; n++) send_pixel(rand_pixel());
		drain();
		ready_free = 1'b0;
	endtask

	// Receiver: random stalls, free-running stretches, one long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 200;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (ready_free)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Output check and watchdog
	always @(posedge clk) begin
		logic [31:0] want;
		if (m_tvalid && m_tready) begin
			if (pixels_due.size() == 0) begin
				$error("unexpected output beat %h", m_tdata);
				fail_count++;
			end else begin
				want = pixels_due.pop_front();
				if (m_tdata[7:0] !== want[7:0]) begin
					$error("out_red: expected %0d actual %0d", want[7:0], m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[15:8] !== want[15:8]) begin
					$error("out_green: expected %0d actual %0d", want[15:8], m_tdata[15:8]);
					fail_count++;
				end
				if (m_tdata[23:16] !== want[23:16]) begin
					$error("out_blue: expected %0d actual %0d", want[23:16], m_tdata[23:16]);
					fail_count++;
				end
				if (m_tdata[31:24] !== want[31:24]) begin
					$error("out_alpha: expected %0d actual %0d", want[31:24], m_tdata[31:24]);
					fail_count++;
				end
			end
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		longint x, r, t;
		for (int c = 0; c < 256; c++) begin
			x = (longint'(c) << 32) / 255;
			r = 0;
			for (int b = 16; b >= 0; b--) begin
				t = r + (longint'(1) << b);
				if (t * t <= x) r = t;
			end
			sq_lut[c] = r;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corners();
		test_all_modes(50);
		test_backpressure();
		test_full_rate();
		write_mode(MODE_EXCLUSION);
		for (int n = 0; n < 10; n++) send_pixel(rand_pixel());
		drain();
		if (pixels_due.size() != 0) fail_count++;
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
